@@ rtl/bba_pkg.sv @@
// Buddy block allocator package: beat types, node states and status codes.
// No dependencies.
package bba_pkg;

  typedef logic [1:0] node_st_t;
  localparam node_st_t NodeAbsent = 2'd0;
  localparam node_st_t NodeFree   = 2'd1;
  localparam node_st_t NodeSplit  = 2'd2;
  localparam node_st_t NodeUsed   = 2'd3;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusTooLarge = 2'd1;
  localparam logic [1:0] StatusNoFit    = 2'd2;
  localparam logic [1:0] StatusNotFound = 2'd3;

  typedef struct packed {
    logic       command;
    logic [6:0] request_size;
    logic [5:0] block_start;
    logic [5:0] block_end;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] granted_start;
    logic [5:0] granted_end;
  } rsp_t;

endpackage

@@ rtl/buddy_block_allocator.sv @@
// Buddy block allocator: tree of node states in one synchronous memory.
// Throughput: one request at a time; the scan over the node memory bounds it.
// Reset: a clearing pass writes every node (root free) with in_stall_o high;
// the result register sits between the two channels.
// Depends on bba_pkg.
module buddy_block_allocator #(
  parameter int unsigned POOL_UNITS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bba_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bba_pkg::rsp_t out_data_o
);
  import bba_pkg::*;

  localparam int unsigned Nodes = 2 * POOL_UNITS - 1;
  localparam int unsigned Lg = $clog2(POOL_UNITS);
  localparam int unsigned IW = $clog2(Nodes + 1);
  localparam int unsigned DW = $clog2(Lg + 2);
  localparam int unsigned SW = Lg + 1;

  localparam logic [3:0] SClr = 4'd0, SIdle = 4'd1, SScanRd = 4'd2, SScanCk = 4'd3,
                         SSplit = 4'd4, SFreeRd = 4'd5, SFreeCk = 4'd6, SBudRd = 4'd7,
                         SBudCk = 4'd8, SDone = 4'd9, SMrgSelf = 4'd10, SMrgPar = 4'd11;

  node_st_t mem [Nodes];
  node_st_t rd_q;
  logic          we;
  logic [IW-1:0] wa;
  node_st_t      wd;
  logic [IW-1:0] ra;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  logic [3:0]    st_q, st_d;
  logic [IW-1:0] idx_q, idx_d, k_q, k_d, best_q, best_d;
  logic [DW-1:0] d_q, d_d, bd_q, bd_d;
  logic          found_q, found_d;
  logic [SW-1:0] req_q, req_d;
  logic          ov_q, ov_d;
  rsp_t          rsp_q, rsp_d;

  function automatic logic [SW:0] lsize(logic [DW-1:0] d);
    return (SW+1)'(POOL_UNITS) >> d;
  endfunction
  function automatic logic [IW-1:0] lbase(logic [DW-1:0] d);
    return IW'((IW+1)'(1) << d) - IW'(1);
  endfunction

  logic [SW:0] sz, bsz;
  logic [IW-1:0] cnt;
  logic [IW:0] lft;
  logic [SW:0] gstart;
  logic [6:0]  sreq;
  logic [5:0]  len6;
  logic [6:0]  flen;
  logic [IW-1:0] fidx;
  logic          fok;
  logic [IW-1:0] bud, par;

  always_comb begin
    sz  = lsize(d_q);
    bsz = lsize(bd_q);
    cnt = IW'((IW+1)'(1) << d_q);
    lft = {best_q, 1'b1};
    gstart = (SW+1)'(best_q - lbase(bd_q)) * bsz;
    sreq = (in_data_i.request_size == 7'd0) ? 7'd1 : in_data_i.request_size;
    len6 = in_data_i.block_end - in_data_i.block_start;
    flen = {1'b0, len6} + 7'd1;
    fok  = 1'b0;
    fidx = '0;
    for (int i = 0; i <= Lg; i++) begin
      if (32'(flen) == (POOL_UNITS >> i) &&
          ((32'(in_data_i.block_start) & ((POOL_UNITS >> i) - 1)) == 0)) begin
        fok  = 1'b1;
        fidx = IW'((1 << i) - 1 + (32'(in_data_i.block_start) >> (Lg - i)));
      end
    end
    if (in_data_i.block_end < in_data_i.block_start ||
        32'(in_data_i.block_end) >= POOL_UNITS) fok = 1'b0;
    bud = idx_q[0] ? idx_q + IW'(1) : idx_q - IW'(1);
    par = (idx_q - IW'(1)) >> 1;
  end

  always_comb begin
    st_d = st_q; idx_d = idx_q; k_d = k_q; best_d = best_q; d_d = d_q; bd_d = bd_q;
    found_d = found_q; req_d = req_q; ov_d = ov_q; rsp_d = rsp_q;
    we = 1'b0; wa = idx_q; wd = NodeAbsent; ra = idx_q;
    in_stall_o = 1'b1;
    case (st_q)
      SClr: begin
        we = 1'b1; wa = idx_q; wd = (idx_q == '0) ? NodeFree : NodeAbsent;
        idx_d = idx_q + IW'(1);
        if (idx_q == IW'(Nodes - 1)) st_d = SIdle;
      end
      SIdle: begin
        in_stall_o = ov_q;
        if (in_valid_i && !ov_q) begin
          rsp_d = '0;
          if (in_data_i.command == CmdAlloc) begin
            if (32'(sreq) > POOL_UNITS) begin
              rsp_d.status = StatusTooLarge; ov_d = 1'b1;
            end else begin
              req_d = SW'(sreq); d_d = '0; k_d = '0; found_d = 1'b0;
              st_d = SScanRd;
            end
          end else if (fok) begin
            idx_d = fidx; st_d = SFreeRd;
          end else begin
            rsp_d.status = StatusNotFound; ov_d = 1'b1;
          end
        end
      end
      SScanRd: begin
        ra = lbase(d_q) + k_q; st_d = SScanCk;
      end
      SScanCk: begin
        st_d = SScanRd;
        if (rd_q == NodeFree || k_q == cnt - IW'(1)) begin
          if (rd_q == NodeFree) begin
            found_d = 1'b1; best_d = lbase(d_q) + k_q; bd_d = d_q;
          end
          k_d = '0; d_d = d_q + DW'(1);
          if (32'(d_q) == Lg || (sz >> 1) < (SW+1)'(req_q)) begin
            if (rd_q == NodeFree || found_q) st_d = SSplit;
            else begin
              rsp_d.status = StatusNoFit; ov_d = 1'b1; st_d = SIdle;
            end
          end
        end else k_d = k_q + IW'(1);
      end
      SSplit: begin
        if (bsz >= (SW+1)'(2) && (bsz >> 1) >= (SW+1)'(req_q)) begin
          we = 1'b1; wa = best_q; wd = NodeSplit;
          best_d = lft[IW-1:0]; bd_d = bd_q + DW'(1);
          st_d = SDone; idx_d = lft[IW-1:0] + IW'(1);
        end else begin
          we = 1'b1; wa = best_q; wd = NodeUsed;
          rsp_d.status = StatusOk;
          rsp_d.granted_start = 6'(gstart);
          rsp_d.granted_end = 6'(gstart + bsz - (SW+1)'(1));
          ov_d = 1'b1; st_d = SIdle;
        end
      end
      SDone: begin
        // write the right half of a split as free; SSplit then splits the left or marks it used
        we = 1'b1; wa = idx_q; wd = NodeFree; st_d = SSplit;
      end
      SFreeRd: begin
        ra = idx_q; st_d = SFreeCk;
      end
      SFreeCk: begin
        if (rd_q == NodeUsed) begin
          we = 1'b1; wa = idx_q; wd = NodeFree;
          rsp_d.status = StatusOk;
          st_d = (idx_q == '0) ? SIdle : SBudRd;
          if (idx_q == '0) ov_d = 1'b1;
        end else begin
          rsp_d.status = StatusNotFound; ov_d = 1'b1; st_d = SIdle;
        end
      end
      SBudRd: begin
        ra = bud; st_d = SBudCk;
      end
      SBudCk: begin
        if (rd_q == NodeFree) begin
          we = 1'b1; wa = bud; wd = NodeAbsent;
          st_d = SMrgSelf;
        end else begin
          ov_d = 1'b1; st_d = SIdle;
        end
      end
      SMrgSelf: begin
        we = 1'b1; wa = idx_q; wd = NodeAbsent; st_d = SMrgPar;
      end
      SMrgPar: begin
        we = 1'b1; wa = par; wd = NodeFree; idx_d = par;
        if (par == '0) begin
          ov_d = 1'b1; st_d = SIdle;
        end else st_d = SBudRd;
      end
      default: st_d = SIdle;
    endcase
    if (ov_q && !out_stall_i) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClr; idx_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; best_q <= best_d; d_q <= d_d; bd_q <= bd_d;
    found_q <= found_d; req_q <= req_d; rsp_q <= rsp_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = rsp_q;
endmodule

@@ rtl/bba_checker.sv @@
// Port checker for the buddy block allocator, bound to buddy_block_allocator.
// Depends on bba_pkg.
module bba_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input bba_pkg::req_t in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bba_pkg::rsp_t out_data_o
);
  import bba_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled beat changed");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StatusOk |->
      out_data_o.granted_start == '0 && out_data_o.granted_end == '0)
    else $error("error beat with bounds");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.status[0] && out_data_o.status == StatusOk |->
      out_data_o.granted_end >= out_data_o.granted_start)
    else $error("bad bounds");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
